// File: design/sgw_pkg.sv
// Shared types, constants and ROM tables of the softmax gating weight update block.
`default_nettype none

package sgw_pkg;

    // serial divider geometry
    localparam int NUM_W = 40;
    localparam int DEN_W = 20;

    // configuration port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_TEMP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOMENTUM   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_W_FLOOR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_W_CEILING  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ADAPTIVE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_FLOOR = 3'd5;

    // register reset values
    localparam logic [15:0] RST_BASE_TEMP  = 16'd4096;
    localparam logic [15:0] RST_MOMENTUM   = 16'd58982;
    localparam logic [15:0] RST_W_FLOOR    = 16'd1638;
    localparam logic [15:0] RST_W_CEILING  = 16'd31130;
    localparam logic [15:0] RST_TEMP_FLOOR = 16'd410;

    // fixed-point constants
    localparam logic [15:0] Q_ONE     = 16'd32768;
    localparam logic [20:0] LN2_Q16   = 21'd45426;
    localparam logic [19:0] LOG2E_Q16 = 20'd94548;
    localparam logic [63:0] LN2_Q32   = 64'd2977044472;

    typedef logic [16:0] rom_t [257];
    typedef logic [19:0] lncnt_t [16];

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
    } div_rsp_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SCAN,
        S_P_DIV,
        S_P_WAIT,
        S_LN_NORM,
        S_LN_T0,
        S_LN_T1,
        S_LN_NL,
        S_H_MUL,
        S_R_DIV,
        S_R_WAIT,
        S_TEMP,
        S_A_DIV,
        S_A_WAIT,
        S_B_MUL,
        S_E_T0,
        S_E_T1,
        S_E_ACC,
        S_S_DIV,
        S_S_WAIT,
        S_EMA0,
        S_EMA1,
        S_EMA_ACC,
        S_N_DIV,
        S_N_WAIT,
        S_DONE
    } seq_state_t;

    // 2^(-k/256) in Q16, alternating series of e^-y
    function automatic rom_t build_exp2();
        rom_t         tab;
        logic [63:0]  y;
        logic [63:0]  term;
        logic [63:0]  pos;
        logic [63:0]  neg;
        logic [127:0] prod;
        for (int k = 0; k <= 256; k++) begin
            y    = (64'(k) * LN2_Q32) / 64'd256;
            term = 64'h1_0000_0000;
            pos  = term;
            neg  = 64'd0;
            for (int i = 1; i <= 24; i++) begin
                prod = 128'(term) * 128'(y);
                term = 64'(prod >> 32) / 64'(i);
                if (i[0]) neg = neg + term;
                else      pos = pos + term;
            end
            tab[k] = 17'((pos - neg + 64'd32768) >> 16);
        end
        return tab;
    endfunction

    // ln(1 + k/256) in Q16, atanh series
    function automatic rom_t build_ln1p();
        rom_t        tab;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] zp;
        logic [63:0] s;
        for (int k = 0; k <= 256; k++) begin
            z  = (64'(k) << 32) / 64'(512 + k);
            z2 = 64'((128'(z) * 128'(z)) >> 32);
            zp = z;
            s  = 64'd0;
            for (int i = 0; i < 20; i++) begin
                s  = s + zp / 64'(2 * i + 1);
                zp = 64'((128'(zp) * 128'(z2)) >> 32);
            end
            tab[k] = 17'((64'd2 * s + 64'd32768) >> 16);
        end
        return tab;
    endfunction

    localparam rom_t EXP2_ROM = build_exp2();
    localparam rom_t LN1P_ROM = build_ln1p();

    // ln(count) in Q16 for the entropy normalization
    function automatic lncnt_t build_ln_cnt();
        lncnt_t      tab;
        logic [31:0] x;
        logic [31:0] mn;
        logic [15:0] f;
        logic [63:0] ip;
        int          b;
        for (int c = 0; c < 16; c++) begin
            tab[c] = 20'd0;
            if (c >= 2) begin
                x = 32'(c) << 16;
                b = 31;
                while (b > 0 && !x[b]) b--;
                mn = x >> (b - 16);
                f  = mn[15:0];
                ip = (64'(LN1P_ROM[f[15:8]]) * 64'(256 - int'(f[7:0]))
                      + 64'(LN1P_ROM[int'(f[15:8]) + 1]) * 64'(f[7:0]) + 64'd128) >> 8;
                tab[c] = 20'(64'(b - 16) * 64'(LN2_Q16) + ip);
            end
        end
        return tab;
    endfunction

    localparam lncnt_t LN_CNT_ROM = build_ln_cnt();

endpackage

`default_nettype wire

// File: design/sgw_if.sv
// Frame and result channel interfaces of the gating weight update block.
`default_nettype none

interface sgw_frame_if #(parameter int N = 4);
    logic          valid;
    logic          ready;
    logic [16*N-1:0] quality;
    logic [N-1:0]  active_mask;

    modport source (output valid, output quality, output active_mask, input ready);
    modport sink   (input valid, input quality, input active_mask, output ready);
endinterface

interface sgw_result_if #(parameter int N = 4);
    logic          valid;
    logic          ready;
    logic [16*N-1:0] weight;
    logic          fallback;

    modport source (output valid, output weight, output fallback, input ready);
    modport sink   (input valid, input weight, input fallback, output ready);
endinterface

`default_nettype wire

// File: design/sgw_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, shared by the sequencer.
`default_nettype none

module sgw_div (
    input  logic              clk,
    input  logic              rst_n,
    input  sgw_pkg::div_req_t req,
    output sgw_pkg::div_rsp_t rsp
);
    import sgw_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        diff      = trial - {1'b0, den_reg};
        if (req.start)
        begin
            quo_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = diff[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

endmodule

`default_nettype wire

// File: design/softmax_gating_weight_update.sv
// Top level: sequencer, shared multiplier and state of the softmax gating weight update.
//
//  channel  | dir | transfer when   | payload
//  ---------+-----+-----------------+------------------------------------------
//  frame    | in  | valid && ready  | quality (16b per modality), active_mask
//  result   | out | valid && ready  | weight (16b per modality), fallback
//  cfg      | in  | cfg_we          | cfg_index, cfg_data (write only)
//
//  Work: a frame with no active modality goes straight to the result. Otherwise
//  each modality needs three divides (exponent argument, softmax share,
//  renormalize) plus one more in adaptive mode, each done in the serial
//  divider (40 quotient bits), plus table and multiply steps.
//  Reset: async, clears the sequencer and loads the default registers and
//  uniform weights; no clearing pass. frame.ready is high only while idle.
//  A finished result sits in the output register; the next frame is taken
//  while it waits, and a later result stalls there until it drains.
`default_nettype none

module softmax_gating_weight_update #(
    parameter int NUM_MODALITIES = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    sgw_frame_if.sink                     frame,
    sgw_result_if.source                  result,
    input  logic                          cfg_we,
    input  logic [sgw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sgw_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sgw_pkg::*;

    localparam int N     = NUM_MODALITIES;
    localparam int IDX_W = $clog2(N);
    localparam int CNT_W = $clog2(N + 1);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(N - 1);
    localparam logic [15:0]      UNIFORM_W = 16'(32768 / N);

    // sequencer
    seq_state_t state_reg, state_next;

    // configuration and persistent state
    logic [15:0] base_t_reg, base_t_next;
    logic [15:0] mom_reg, mom_next;
    logic [15:0] wfloor_reg, wfloor_next;
    logic [15:0] wceil_reg, wceil_next;
    logic        adapt_reg, adapt_next;
    logic [15:0] tfloor_reg, tfloor_next;
    logic [15:0] live_t_reg, live_t_next;
    logic [15:0] sw_reg [N];
    logic [15:0] sw_next [N];

    // output register
    logic            out_valid_reg, out_valid_next;
    logic [16*N-1:0] out_w_reg, out_w_next;
    logic            out_fb_reg, out_fb_next;

    // working registers
    logic [15:0]      q_reg [N];
    logic [15:0]      q_next [N];
    logic [N-1:0]     mask_reg, mask_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             fb_reg, fb_next;
    logic [19:0]      qsum_reg, qsum_next;
    logic [15:0]      mx_reg, mx_next;
    logic [23:0]      h_reg, h_next;
    logic [16:0]      p_reg, p_next;
    logic [16:0]      x_reg, x_next;
    logic [4:0]       sh_reg, sh_next;
    logic [19:0]      nl_reg, nl_next;
    logic [16:0]      r_reg, r_next;
    logic [28:0]      a_reg, a_next;
    logic [15:0]      frac_reg, frac_next;
    logic [4:0]       n_reg, n_next;
    logic [47:0]      acc_reg, acc_next;
    logic [16:0]      e_reg [N];
    logic [16:0]      e_next [N];
    logic [19:0]      esum_reg, esum_next;
    logic [15:0]      s_reg, s_next;
    logic [15:0]      w_reg [N];
    logic [15:0]      w_next [N];
    logic [19:0]      wsum_reg, wsum_next;

    // shared multiplier
    logic [28:0] mul_a;
    logic [19:0] mul_b;
    logic [48:0] prod;

    div_req_t div_req;
    div_rsp_t div_rsp;

    // combinational helpers
    logic [8:0]  rom_ix0;
    logic [8:0]  rom_ix1;
    logic [8:0]  lo_inv;
    logic [16:0] interp;
    logic [15:0] t_eff;
    logic [15:0] q_cur;
    logic        is_last;

    sgw_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign rom_ix0 = {1'b0, frac_reg[15:8]};
    assign rom_ix1 = rom_ix0 + 9'd1;
    assign lo_inv  = 9'd256 - {1'b0, frac_reg[7:0]};
    assign interp  = acc_reg[24:8];
    assign t_eff   = (live_t_reg == 16'd0) ? 16'd1 : live_t_reg;
    assign q_cur   = q_reg[idx_reg];
    assign is_last = (idx_reg == LAST_IDX);

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_LN_T0:
            begin
                mul_a = 29'(LN1P_ROM[rom_ix0]);
                mul_b = 20'(lo_inv);
            end
            S_LN_T1:
            begin
                mul_a = 29'(LN1P_ROM[rom_ix1]);
                mul_b = 20'(frac_reg[7:0]);
            end
            S_E_T0:
            begin
                mul_a = 29'(EXP2_ROM[rom_ix0]);
                mul_b = 20'(lo_inv);
            end
            S_E_T1:
            begin
                mul_a = 29'(EXP2_ROM[rom_ix1]);
                mul_b = 20'(frac_reg[7:0]);
            end
            S_H_MUL:
            begin
                mul_a = 29'(p_reg);
                mul_b = nl_reg;
            end
            S_TEMP:
            begin
                mul_a = 29'(base_t_reg);
                mul_b = 20'(18'd65536 + 18'(r_reg));
            end
            S_B_MUL:
            begin
                mul_a = a_reg;
                mul_b = LOG2E_Q16;
            end
            S_EMA0:
            begin
                mul_a = 29'(mom_reg);
                mul_b = 20'(sw_reg[idx_reg]);
            end
            S_EMA1:
            begin
                mul_a = 29'(17'd65536 - 17'(mom_reg));
                mul_b = 20'(s_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = 49'(mul_a) * 49'(mul_b);

    // sequencer and datapath
    always_comb
    begin
        logic [15:0]      qv;
        logic [CNT_W-1:0] cnt_in;
        logic [19:0]      qsum_sum;
        logic [20:0]      ln_int;
        logic [48:0]      tmp;
        logic [16:0]      t_full;
        logic [29:0]      b16;
        logic [16:0]      e_val;
        logic [16:0]      s_val;
        logic [15:0]      w_val;
        logic [19:0]      esum_sum;
        logic [19:0]      wsum_sum;

        state_next     = state_reg;
        base_t_next    = base_t_reg;
        mom_next       = mom_reg;
        wfloor_next    = wfloor_reg;
        wceil_next     = wceil_reg;
        adapt_next     = adapt_reg;
        tfloor_next    = tfloor_reg;
        live_t_next    = live_t_reg;
        sw_next        = sw_reg;
        out_valid_next = out_valid_reg;
        out_w_next     = out_w_reg;
        out_fb_next    = out_fb_reg;
        q_next         = q_reg;
        mask_next      = mask_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        fb_next        = fb_reg;
        qsum_next      = qsum_reg;
        mx_next        = mx_reg;
        h_next         = h_reg;
        p_next         = p_reg;
        x_next         = x_reg;
        sh_next        = sh_reg;
        nl_next        = nl_reg;
        r_next         = r_reg;
        a_next         = a_reg;
        frac_next      = frac_reg;
        n_next         = n_reg;
        acc_next       = acc_reg;
        e_next         = e_reg;
        esum_next      = esum_reg;
        s_next         = s_reg;
        w_next         = w_reg;
        wsum_next      = wsum_reg;
        div_req        = '0;
        qv             = '0;
        cnt_in         = '0;
        qsum_sum       = '0;
        ln_int         = '0;
        tmp            = '0;
        t_full         = '0;
        b16            = '0;
        e_val          = '0;
        s_val          = '0;
        w_val          = '0;
        esum_sum       = '0;
        wsum_sum       = '0;

        if (out_valid_reg && result.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (frame.valid)
                begin
                    for (int m = 0; m < N; m++)
                    begin
                        qv = frame.quality[16*m +: 16];
                        if (qv > Q_ONE)
                            qv = Q_ONE;
                        q_next[m] = frame.active_mask[m] ? qv : 16'd0;
                    end
                    cnt_in    = CNT_W'($countones(frame.active_mask));
                    mask_next = frame.active_mask;
                    cnt_next  = cnt_in;
                    idx_next  = '0;
                    qsum_next = '0;
                    mx_next   = '0;
                    h_next    = '0;
                    esum_next = '0;
                    wsum_next = '0;
                    fb_next   = (cnt_in == '0);
                    state_next = (cnt_in == '0) ? S_DONE : S_SCAN;
                end
            end

            S_SCAN:
            begin
                qsum_sum  = qsum_reg + 20'(q_cur);
                qsum_next = qsum_sum;
                if (q_cur > mx_reg)
                    mx_next = q_cur;
                if (is_last)
                begin
                    idx_next = '0;
                    if (!adapt_reg)
                        state_next = S_A_DIV;
                    else if (qsum_sum == '0)
                        state_next = S_R_DIV;
                    else
                        state_next = S_P_DIV;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end

            // entropy: p = round(q / qsum) in Q1.16
            S_P_DIV:
            begin
                div_req.start = 1'b1;
                div_req.num   = (NUM_W'(q_cur) << 16) + NUM_W'(qsum_reg >> 1);
                div_req.den   = qsum_reg;
                state_next    = S_P_WAIT;
            end

            S_P_WAIT:
            begin
                if (div_rsp.done)
                begin
                    p_next = div_rsp.quot[16:0];
                    if (div_rsp.quot[16:0] == '0)
                    begin
                        if (is_last)
                        begin
                            idx_next   = '0;
                            state_next = S_R_DIV;
                        end
                        else
                        begin
                            idx_next   = idx_reg + 1'b1;
                            state_next = S_P_DIV;
                        end
                    end
                    else
                    begin
                        x_next     = div_rsp.quot[16:0];
                        sh_next    = '0;
                        state_next = S_LN_NORM;
                    end
                end
            end

            // one bit of normalization per cycle
            S_LN_NORM:
            begin
                if (x_reg[16])
                begin
                    frac_next  = x_reg[15:0];
                    state_next = S_LN_T0;
                end
                else
                begin
                    x_next  = {x_reg[15:0], 1'b0};
                    sh_next = sh_reg + 1'b1;
                end
            end

            S_LN_T0:
            begin
                acc_next   = 48'(prod) + 48'd128;
                state_next = S_LN_T1;
            end

            S_LN_T1:
            begin
                acc_next   = acc_reg + 48'(prod);
                state_next = S_LN_NL;
            end

            // -ln p = sh*ln2 - ln(1+f)
            S_LN_NL:
            begin
                ln_int = 21'(sh_reg) * LN2_Q16;
                if (ln_int > 21'(interp))
                    nl_next = 20'(ln_int - 21'(interp));
                else
                    nl_next = '0;
                state_next = S_H_MUL;
            end

            S_H_MUL:
            begin
                h_next = h_reg + 24'(prod >> 16);
                if (is_last)
                begin
                    idx_next   = '0;
                    state_next = S_R_DIV;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_P_DIV;
                end
            end

            S_R_DIV:
            begin
                if (cnt_reg >= CNT_W'(2))
                begin
                    div_req.start = 1'b1;
                    div_req.num   = NUM_W'(h_reg) << 16;
                    div_req.den   = LN_CNT_ROM[4'(cnt_reg)];
                    state_next    = S_R_WAIT;
                end
                else
                begin
                    r_next     = 17'd65536;
                    state_next = S_TEMP;
                end
            end

            S_R_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quot > NUM_W'(65536))
                        r_next = 17'd65536;
                    else
                        r_next = div_rsp.quot[16:0];
                    state_next = S_TEMP;
                end
            end

            S_TEMP:
            begin
                tmp    = prod + 49'd65536;
                t_full = 17'(tmp >> 17);
                if (t_full < 17'(tfloor_reg))
                    live_t_next = tfloor_reg;
                else
                    live_t_next = t_full[15:0];
                idx_next   = '0;
                state_next = S_A_DIV;
            end

            // softmax: a = (max - q) / T in Q16
            S_A_DIV:
            begin
                div_req.start = 1'b1;
                div_req.num   = NUM_W'(mx_reg - q_cur) << 13;
                div_req.den   = DEN_W'(t_eff);
                state_next    = S_A_WAIT;
            end

            S_A_WAIT:
            begin
                if (div_rsp.done)
                begin
                    a_next     = div_rsp.quot[28:0];
                    state_next = S_B_MUL;
                end
            end

            S_B_MUL:
            begin
                tmp = prod + 49'd32768;
                b16 = 30'(tmp >> 16);
                if (b16[29:16] >= 14'd17)
                begin
                    e_next[idx_reg] = '0;
                    if (is_last)
                    begin
                        idx_next = '0;
                        if (esum_reg == '0)
                            esum_next = 20'd1;
                        state_next = S_S_DIV;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_A_DIV;
                    end
                end
                else
                begin
                    frac_next  = b16[15:0];
                    n_next     = b16[20:16];
                    state_next = S_E_T0;
                end
            end

            S_E_T0:
            begin
                acc_next   = 48'(prod) + 48'd128;
                state_next = S_E_T1;
            end

            S_E_T1:
            begin
                acc_next   = acc_reg + 48'(prod);
                state_next = S_E_ACC;
            end

            S_E_ACC:
            begin
                e_val           = interp >> n_reg;
                e_next[idx_reg] = e_val;
                esum_sum        = esum_reg + 20'(e_val);
                esum_next       = esum_sum;
                if (is_last)
                begin
                    idx_next = '0;
                    if (esum_sum == '0)
                        esum_next = 20'd1;
                    state_next = S_S_DIV;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_A_DIV;
                end
            end

            S_S_DIV:
            begin
                div_req.start = 1'b1;
                div_req.num   = (NUM_W'(e_reg[idx_reg]) << 15) + NUM_W'(esum_reg >> 1);
                div_req.den   = esum_reg;
                state_next    = S_S_WAIT;
            end

            // clamp to floor, else to ceiling (floor checked first); inactive modalities get zero
            S_S_WAIT:
            begin
                if (div_rsp.done)
                begin
                    s_val = div_rsp.quot[16:0];
                    if (s_val < 17'(wfloor_reg))
                        s_val = 17'(wfloor_reg);
                    else if (s_val > 17'(wceil_reg))
                        s_val = 17'(wceil_reg);
                    if (!mask_reg[idx_reg])
                        s_val = '0;
                    s_next     = s_val[15:0];
                    state_next = S_EMA0;
                end
            end

            S_EMA0:
            begin
                acc_next   = 48'(prod) + 48'd32768;
                state_next = S_EMA1;
            end

            S_EMA1:
            begin
                acc_next   = acc_reg + 48'(prod);
                state_next = S_EMA_ACC;
            end

            // state takes the EMA value; renormalize overwrites it if possible
            S_EMA_ACC:
            begin
                w_val            = acc_reg[31:16];
                w_next[idx_reg]  = w_val;
                sw_next[idx_reg] = w_val;
                wsum_sum         = wsum_reg + 20'(w_val);
                wsum_next        = wsum_sum;
                if (is_last)
                begin
                    idx_next   = '0;
                    state_next = (wsum_sum == '0) ? S_DONE : S_N_DIV;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_S_DIV;
                end
            end

            S_N_DIV:
            begin
                div_req.start = 1'b1;
                div_req.num   = (NUM_W'(w_reg[idx_reg]) << 15) + NUM_W'(wsum_reg >> 1);
                div_req.den   = wsum_reg;
                state_next    = S_N_WAIT;
            end

            S_N_WAIT:
            begin
                if (div_rsp.done)
                begin
                    w_next[idx_reg]  = div_rsp.quot[15:0];
                    sw_next[idx_reg] = div_rsp.quot[15:0];
                    if (is_last)
                        state_next = S_DONE;
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_N_DIV;
                    end
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    for (int m = 0; m < N; m++)
                        out_w_next[16*m +: 16] = fb_reg ? UNIFORM_W : w_reg[m];
                    out_fb_next    = fb_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // config writes must arrive only while idle; the block itself does not enforce this
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BASE_TEMP:
                begin
                    base_t_next = cfg_data;
                    live_t_next = cfg_data;
                end
                CFG_MOMENTUM:   mom_next    = cfg_data;
                CFG_W_FLOOR:    wfloor_next = cfg_data;
                CFG_W_CEILING:  wceil_next  = cfg_data;
                CFG_ADAPTIVE:   adapt_next  = cfg_data[0];
                CFG_TEMP_FLOOR: tfloor_next = cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            base_t_reg    <= RST_BASE_TEMP;
            mom_reg       <= RST_MOMENTUM;
            wfloor_reg    <= RST_W_FLOOR;
            wceil_reg     <= RST_W_CEILING;
            adapt_reg     <= 1'b0;
            tfloor_reg    <= RST_TEMP_FLOOR;
            live_t_reg    <= RST_BASE_TEMP;
            for (int m = 0; m < N; m++)
                sw_reg[m] <= UNIFORM_W;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_t_reg    <= base_t_next;
            mom_reg       <= mom_next;
            wfloor_reg    <= wfloor_next;
            wceil_reg     <= wceil_next;
            adapt_reg     <= adapt_next;
            tfloor_reg    <= tfloor_next;
            live_t_reg    <= live_t_next;
            sw_reg        <= sw_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_w_reg  <= out_w_next;
        out_fb_reg <= out_fb_next;
        q_reg      <= q_next;
        mask_reg   <= mask_next;
        cnt_reg    <= cnt_next;
        idx_reg    <= idx_next;
        fb_reg     <= fb_next;
        qsum_reg   <= qsum_next;
        mx_reg     <= mx_next;
        h_reg      <= h_next;
        p_reg      <= p_next;
        x_reg      <= x_next;
        sh_reg     <= sh_next;
        nl_reg     <= nl_next;
        r_reg      <= r_next;
        a_reg      <= a_next;
        frac_reg   <= frac_next;
        n_reg      <= n_next;
        acc_reg    <= acc_next;
        e_reg      <= e_next;
        esum_reg   <= esum_next;
        s_reg      <= s_next;
        w_reg      <= w_next;
        wsum_reg   <= wsum_next;
    end

    assign frame.ready     = (state_reg == S_IDLE);
    assign result.valid    = out_valid_reg;
    assign result.weight   = out_w_reg;
    assign result.fallback = out_fb_reg;

endmodule

`default_nettype wire
